FILE: sv/skl_pkg.sv
// Shared types, token codes and keyword table for the schema keyword lexer.
`timescale 1ns / 1ps
package skl_pkg;

  localparam longint unsigned MaxTextBytes = 64'd65536;
  localparam int unsigned KeywordChars = 8;

  localparam int unsigned KwCount = 13;
  localparam int unsigned KwMaxLen = 8;

  localparam logic [4:0] TkEnd = 5'd0;
  localparam logic [4:0] TkLcurly = 5'd1;
  localparam logic [4:0] TkRcurly = 5'd2;
  localparam logic [4:0] TkSemi = 5'd3;
  localparam logic [4:0] TkKwFirst = 5'd4;
  localparam logic [4:0] TkIdent = 5'd17;
  localparam logic [4:0] TkError = 5'd18;

  localparam int unsigned FifoDepth = 16;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);
  localparam int unsigned ResultsMax = 3;
  // worst case: one request in the input register plus one being accepted
  localparam logic [FifoCntW-1:0] ReadyLevel = FifoCntW'(FifoDepth - 2 * ResultsMax);

  localparam logic [7:0] KwText [KwCount][KwMaxLen] = '{
    '{"g", "r", "o", "u", "p", 8'h00, 8'h00, 8'h00},
    '{"m", "e", "s", "s", "a", "g", "e", 8'h00},
    '{"r", "e", "q", "u", "i", "r", "e", "d"},
    '{"o", "p", "t", "i", "o", "n", "a", "l"},
    '{"r", "e", "p", "e", "a", "t", "e", "d"},
    '{"i", "n", "t", "3", "2", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", "6", "4", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", "9", "6", 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
    '{"b", "i", "n", "a", "r", "y", 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"b", "o", "o", "l", "e", "a", "n", 8'h00}
  };

  localparam logic [3:0] KwLen [KwCount] = '{
    4'd5, 4'd7, 4'd8, 4'd8, 4'd8, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] word_offset;
    logic [15:0] word_length;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0]                    count;
    token_t [ResultsMax-1:0]       item;
  } push_t;

  function automatic logic [4:0] classify(input logic [KwMaxLen-1:0][7:0] p,
                                          input logic [15:0] n);
    logic [4:0] kind;
    logic       hit;
    kind = TkIdent;
    for (int k = KwCount - 1; k >= 0; k--) begin
      hit = (n == 16'(KwLen[k]));
      for (int i = 0; i < KwMaxLen; i++) begin
        if ((4'(i) < KwLen[k]) && (p[i] != KwText[k][i])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = 5'(TkKwFirst + 5'(k));
      end
    end
    return kind;
  endfunction

endpackage

FILE: sv/schema_keyword_lexer.sv
// Schema keyword lexer top level: input register, lexer core, token queue.
// A request accepted into the input register is lexed in the next cycle; its
// tokens are then written to the token queue and offered on token_valid in order.
// Throughput: one byte per cycle; text_ready stays high while the 16-entry
// token queue holds 10 or fewer tokens, each byte adding up to three.
// Reset: synchronous rst clears lexer word state, input valid flag and queue pointers; no sweep.
`timescale 1ns / 1ps
module schema_keyword_lexer #(
  parameter longint unsigned MAX_TEXT_BYTES = skl_pkg::MaxTextBytes,
  parameter int unsigned KEYWORD_CHARS = skl_pkg::KeywordChars
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            text_valid,
  output logic            text_ready,
  input  skl_pkg::text_t  text,
  output logic            token_valid,
  input  logic            token_ready,
  output skl_pkg::token_t token
);

  logic                          hold_valid;
  skl_pkg::text_t                hold;
  skl_pkg::push_t                push;
  logic [skl_pkg::FifoCntW-1:0]  level;
  logic                          accept;

  assign text_ready = (level <= skl_pkg::ReadyLevel);
  assign accept = text_valid && text_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= text;
    end
  end

  skl_core #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .item_valid(hold_valid),
    .item(hold),
    .push(push)
  );

  skl_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .level(level),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token(token)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= skl_pkg::FifoCntW'(skl_pkg::FifoDepth))
    else $error("token queue overflow");

  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && text.end_of_text) |=> (push.count != 2'd0))
    else $error("final byte produced no tokens");

  a_run_marked: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> push.item[push.count - 2'd1].last_of_run)
    else $error("last token of a request not marked");

  a_no_pad_mark: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd3) |-> (!push.item[0].last_of_run && !push.item[1].last_of_run))
    else $error("early token marked as last");
`endif

endmodule

FILE: sv/skl_core.sv
// Lexer state and per-byte token generation.
`timescale 1ns / 1ps
module skl_core #(
  parameter longint unsigned MAX_TEXT_BYTES = skl_pkg::MaxTextBytes,
  parameter int unsigned KEYWORD_CHARS = skl_pkg::KeywordChars
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  skl_pkg::text_t  item,
  output skl_pkg::push_t  push
);

  localparam longint unsigned CapWide =
    ((MAX_TEXT_BYTES - 64'd1) < 64'd65535) ? (MAX_TEXT_BYTES - 64'd1) : 64'd65535;
  localparam logic [15:0] PosCap = CapWide[15:0];
  localparam int unsigned IdxW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChLcurly = 8'h7B;
  localparam logic [7:0] ChRcurly = 8'h7D;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChUnder = 8'h5F;

  logic [7:0]  prefix [KEYWORD_CHARS];
  logic        in_word, in_word_next;
  logic [15:0] word_start, word_start_next;
  logic [15:0] word_count, word_count_next;
  logic [15:0] byte_position, byte_position_next;
  logic        error_seen, error_seen_next;

  logic [7:0]  c;
  logic        last;
  logic        is_ws, is_punct, is_word, is_bad;
  logic [15:0] base, count_eff, start_eff;
  logic [skl_pkg::KwMaxLen-1:0][7:0] pre_eff;
  logic [4:0]  word_kind, mid_kind;
  logic        live, emit_word, emit_mid, emit_end;
  skl_pkg::token_t cand [skl_pkg::ResultsMax];
  logic [skl_pkg::ResultsMax-1:0] cand_valid;
  logic [1:0]  n;

  assign c = item.text_byte;
  assign last = item.end_of_text;

  assign is_ws = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  assign is_punct = (c == ChLcurly) || (c == ChRcurly) || (c == ChSemi);
  assign is_word = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                   ((c >= 8'h30) && (c <= 8'h39)) || (c == ChUnder);
  assign is_bad = !(is_ws || is_punct || is_word);

  // word state as it stands after this byte
  assign base = in_word ? word_count : 16'd0;
  assign count_eff = is_word ? ((base != 16'hFFFF) ? base + 16'd1 : base) : word_count;
  assign start_eff = (is_word && !in_word) ? byte_position : word_start;

  always_comb begin
    for (int i = 0; i < skl_pkg::KwMaxLen; i++) begin
      pre_eff[i] = (is_word && (base == 16'(i))) ? c : prefix[i];
    end
  end

  assign word_kind = skl_pkg::classify(pre_eff, count_eff);
  assign mid_kind = is_bad ? skl_pkg::TkError :
                    (c == ChLcurly) ? skl_pkg::TkLcurly :
                    (c == ChRcurly) ? skl_pkg::TkRcurly : skl_pkg::TkSemi;

  assign byte_position_next = (byte_position < PosCap) ? byte_position + 16'd1
                                                       : byte_position;

  assign live = item_valid && !error_seen;
  assign emit_word = live && ((in_word && (is_ws || is_punct)) || (last && is_word));
  assign emit_mid = live && (is_punct || is_bad);
  assign emit_end = item_valid && last;

  always_comb begin
    cand[0] = '{token_kind: word_kind, word_offset: start_eff, word_length: count_eff,
                last_of_run: !emit_mid && !emit_end};
    cand[1] = '{token_kind: mid_kind, word_offset: byte_position, word_length: 16'd1,
                last_of_run: !emit_end};
    cand[2] = '{token_kind: skl_pkg::TkEnd, word_offset: byte_position_next,
                word_length: 16'd0, last_of_run: 1'b1};
    cand_valid = {emit_end, emit_mid, emit_word};
    n = 2'd0;
    push.item = '0;
    for (int i = 0; i < skl_pkg::ResultsMax; i++) begin
      if (cand_valid[i]) begin
        push.item[n] = cand[i];
        n = n + 2'd1;
      end
    end
    push.count = n;
  end

  always_comb begin
    in_word_next = in_word;
    word_start_next = word_start;
    word_count_next = word_count;
    error_seen_next = error_seen;
    if (live) begin
      if (is_word) begin
        in_word_next = 1'b1;
        word_start_next = start_eff;
        word_count_next = count_eff;
      end else begin
        in_word_next = 1'b0;
        word_count_next = 16'd0;
        if (is_bad) begin
          error_seen_next = 1'b1;
        end
      end
    end
    if (emit_end) begin
      in_word_next = 1'b0;
      word_start_next = 16'd0;
      word_count_next = 16'd0;
      error_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word <= 1'b0;
      word_start <= 16'd0;
      word_count <= 16'd0;
      byte_position <= 16'd0;
      error_seen <= 1'b0;
    end else if (item_valid) begin
      in_word <= in_word_next;
      word_start <= word_start_next;
      word_count <= word_count_next;
      byte_position <= last ? 16'd0 : byte_position_next;
      error_seen <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (live && is_word && (base < 16'(KEYWORD_CHARS))) begin
      prefix[base[IdxW-1:0]] <= c;
    end
  end

endmodule

FILE: sv/skl_fifo.sv
// Token queue: takes up to three tokens per cycle, hands out one.
`timescale 1ns / 1ps
module skl_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  skl_pkg::push_t                 push,
  output logic [skl_pkg::FifoCntW-1:0]   level,
  output logic                           token_valid,
  input  logic                           token_ready,
  output skl_pkg::token_t                token
);

  skl_pkg::token_t                 mem [skl_pkg::FifoDepth];
  logic [skl_pkg::FifoPtrW-1:0]    wr_ptr, rd_ptr;
  logic [skl_pkg::FifoCntW-1:0]    count;
  logic                            pop;

  assign token_valid = (count != '0);
  assign token = mem[rd_ptr];
  assign pop = token_valid && token_ready;
  assign level = count;

  always_ff @(posedge clk) begin
    for (int i = 0; i < skl_pkg::ResultsMax; i++) begin
      if (2'(i) < push.count) begin
        mem[wr_ptr + skl_pkg::FifoPtrW'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + skl_pkg::FifoPtrW'(push.count);
      rd_ptr <= rd_ptr + skl_pkg::FifoPtrW'(pop);
      count <= count + skl_pkg::FifoCntW'(push.count) - skl_pkg::FifoCntW'(pop);
    end
  end

endmodule

FILE: verif/tb_top.sv
// Testbench for the schema keyword lexer: directed and random schema text with a token scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import skl_pkg::*;

  localparam int IdlePct = 32;
  localparam int RandomBytes = 300;
  localparam int LongWordBytes = 40;
  localparam logic [15:0] PosCap =
    (MaxTextBytes - 1 < 64'd65535) ? 16'(MaxTextBytes - 1) : 16'hFFFF;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   text_valid = 1'b0;
  logic   text_ready;
  text_t  text = '0;
  logic   token_valid;
  logic   token_ready = 1'b0;
  token_t token;

  bit     idle_on = 1'b1;
  int     errors = 0;
  token_t expected_tokens[$];
  token_t byte_tokens[$];

  string keywords[KwCount] = '{"group", "message", "required", "optional", "repeated",
                               "int32", "int64", "int96", "float", "double", "binary",
                               "string", "boolean"};
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  // lexer state mirror
  logic [7:0]  lx_prefix [KeywordChars];
  bit          lx_in_word = 1'b0;
  logic [15:0] lx_start = '0;
  logic [15:0] lx_count = '0;
  logic [15:0] lx_pos = '0;
  bit          lx_error = 1'b0;

  schema_keyword_lexer uut (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text(text),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token(token)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    token_ready <= !(idle_on && $urandom_range(99) < IdlePct);
  end

  function automatic logic [4:0] word_kind();
    int n;
    bit hit;
    for (int k = 0; k < KwCount; k++) begin
      n = keywords[k].len();
      hit = (lx_count == 16'(n));
      for (int i = 0; i < n; i++) begin
        if (hit && lx_prefix[i] != keywords[k][i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        return TkKwFirst + 5'(k);
      end
    end
    return TkIdent;
  endfunction

  function automatic void add_token(logic [4:0] kind, logic [15:0] off, logic [15:0] len);
    token_t t;
    t.token_kind = kind;
    t.word_offset = off;
    t.word_length = len;
    t.last_of_run = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void close_word();
    if (lx_in_word) begin
      add_token(word_kind(), lx_start, lx_count);
      lx_in_word = 1'b0;
      lx_count = '0;
    end
  endfunction

  function automatic bit is_word_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic last);
    logic [15:0] here;
    token_t      tail;
    here = lx_pos;
    byte_tokens.delete();
    if (!lx_error) begin
      if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
        close_word();
      end else if (c == "{" || c == "}" || c == ";") begin
        close_word();
        add_token(c == "{" ? TkLcurly : (c == "}" ? TkRcurly : TkSemi), here, 16'd1);
      end else if (is_word_byte(c)) begin
        if (!lx_in_word) begin
          lx_in_word = 1'b1;
          lx_start = here;
          lx_count = '0;
        end
        if (lx_count < KeywordChars) begin
          lx_prefix[lx_count] = c;
        end
        if (lx_count != 16'hFFFF) begin
          lx_count++;
        end
      end else begin
        // unfinished word is dropped
        lx_in_word = 1'b0;
        lx_count = '0;
        lx_error = 1'b1;
        add_token(TkError, here, 16'd1);
      end
    end
    if (lx_pos < PosCap) begin
      lx_pos++;
    end
    if (last) begin
      if (!lx_error) begin
        close_word();
      end
      add_token(TkEnd, lx_pos, 16'd0);
      lx_in_word = 1'b0;
      lx_start = '0;
      lx_count = '0;
      lx_pos = '0;
      lx_error = 1'b0;
    end
    if (byte_tokens.size() > 0) begin
      tail = byte_tokens.pop_back();
      tail.last_of_run = 1'b1;
      byte_tokens.push_back(tail);
    end
    foreach (byte_tokens[i]) begin
      expected_tokens.push_back(byte_tokens[i]);
    end
  endfunction

  always @(posedge clk) begin
    token_t want;
    if (!rst && token_valid && token_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d offset %0d", token.token_kind, token.word_offset);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (token.token_kind !== want.token_kind) begin
          $error("token_kind: expected %0d, got %0d", want.token_kind, token.token_kind);
          errors++;
        end
        if (token.word_offset !== want.word_offset) begin
          $error("word_offset: expected %0d, got %0d", want.word_offset, token.word_offset);
          errors++;
        end
        if (token.word_length !== want.word_length) begin
          $error("word_length: expected %0d, got %0d", want.word_length, token.word_length);
          errors++;
        end
        if (token.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, token.last_of_run);
          errors++;
        end
      end
    end
  end

  task automatic send(input logic [7:0] c, input logic last);
    text_t item;
    item.text_byte = c;
    item.end_of_text = last;
    while (idle_on && $urandom_range(99) < IdlePct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text <= item;
    @(posedge clk);
    while (!text_ready) begin
      @(posedge clk);
    end
    lex_byte(c, last);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send(s[i], close && i == s.len() - 1);
    end
  endtask

  task automatic wait_drain();
    text_valid <= 1'b0;
    @(negedge clk);
    while (expected_tokens.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_punctuation();
    send_text("{ }\t;\r\n", 1'b1);
    send_text(" ", 1'b1);
    send_text("ab;", 1'b1);
  endtask

  task automatic test_keywords();
    foreach (keywords[k]) begin
      send_text({keywords[k], " "}, 1'b0);
    end
    // last word is closed by the end of text
    send_text("int3 int320 Group booleans _ 9 x_Y7 string", 1'b1);
  endtask

  task automatic test_invalid_bytes();
    send_text("ab#cd {", 1'b1);
    send("x", 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    send(8'h80, 1'b1);
    send("~", 1'b0);
    send(8'h7F, 1'b1);
    send_text("ok", 1'b0);
    send("=", 1'b1);
  endtask

  task automatic test_long_text();
    idle_on = 1'b0;
    send_text("group", 1'b0);
    repeat (LongWordBytes - 5) send("_", 1'b0);
    send_text(";int32}", 1'b1);
    wait_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    int    sent;
    int    pick;
    int    k;
    int    n;
    bit    finish;
    bit    paused;
    string piece;
    sent = 0;
    paused = 1'b0;
    while (sent < RandomBytes) begin
      idle_on = !(sent >= 150 && sent < 250);
      if (sent >= 100 && !paused) begin
        wait_drain();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      k = $urandom_range(KwCount - 1);
      finish = ($urandom_range(14) == 0);
      piece = "";
      if (pick < 30) begin
        piece = keywords[k];
      end else if (pick < 45) begin
        n = $urandom_range(12, 1);
        repeat (n) begin
          n = $urandom_range(word_chars.len() - 1);
          piece = {piece, word_chars.substr(n, n)};
        end
      end else if (pick < 55) begin
        piece = keywords[k];
        case ($urandom_range(2))
          0: piece = piece.substr(0, piece.len() - 2);
          1: piece = {piece, "s"};
          default: piece = piece.toupper();
        endcase
      end else if (pick < 72) begin
        n = $urandom_range(2);
        piece = "{};";
        piece = piece.substr(n, n);
      end else if (pick < 92) begin
        repeat ($urandom_range(3, 1)) begin
          n = $urandom_range(3);
          piece = {piece, " \t\r\n"};
          piece = piece.substr(0, piece.len() - 4 + n);
        end
      end
      if (pick < 55 && $urandom_range(9) < 7) begin
        piece = {piece, " "};
      end
      if (pick >= 92) begin
        send(8'($urandom_range(255)), finish);
        sent++;
      end else begin
        send_text(piece, finish);
        sent += piece.len();
      end
    end
    idle_on = 1'b1;
    send(" ", 1'b1);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_punctuation();
    test_keywords();
    test_invalid_bytes();
    test_long_text();
    test_random();
    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
